// ----- rtl/spjq_pkg.sv -----
package spjq_pkg;

   localparam int QUEUE_DEPTH = 8;

   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_ADDED   = 2'd0,
      ST_FULL    = 2'd1,
      ST_REMOVED = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   typedef struct packed {
      logic [31:0] text;
      logic [15:0] prio;
      logic [15:0] tag;
   } entry_type;

   // what each cell shows its neighbors
   typedef struct packed {
      logic      valid;
      logic      take;
      entry_type entry;
   } cell_io_type;

   // broadcast to every cell
   typedef struct packed {
      logic      ins;
      logic      rem;
      entry_type key;
   } ctl_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] text;
      logic [15:0] prio;
      logic [15:0] tag;
   } rsp_type;

   // new key is served strictly before the stored entry
   function automatic logic goes_before(input entry_type key, input entry_type stored);
      logic result;
      if (key.prio != stored.prio) begin
         result = key.prio < stored.prio;
      end else begin
         result = key.tag < stored.tag;
      end
      return result;
   endfunction

endpackage

// ----- rtl/spjq_if.sv -----
interface spjq_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] job_text;
   logic [15:0] job_priority;
   logic [15:0] arrival_tag;

   modport source (output valid, output command, output job_text,
                   output job_priority, output arrival_tag, input ready);
   modport sink   (input valid, input command, input job_text,
                   input job_priority, input arrival_tag, output ready);
endinterface

interface spjq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] out_text;
   logic [15:0] out_priority;
   logic [15:0] out_tag;

   modport source (output valid, output status, output out_text,
                   output out_priority, output out_tag, input ready);
   modport sink   (input valid, input status, input out_text,
                   input out_priority, input out_tag, output ready);
endinterface

// ----- rtl/stable_priority_job_queue_core.sv -----
// channel   dir  handshake          word
// req_chan  in   valid/ready        command, job_text, job_priority, arrival_tag
// rsp_chan  out  valid/ready        status, out_text, out_priority, out_tag
//
// One command per cycle unless a stalled response holds req_chan.ready low;
// the response follows in the cycle after, as the cell row inserts or shifts.
// Synchronous reset empties every cell; entry data is not cleared.
// A stalled response blocks new commands only until it is taken.
module stable_priority_job_queue_core import spjq_pkg::*; (
   input logic        clock,
   input logic        reset,
   spjq_req_if.sink   req_chan,
   spjq_rsp_if.source rsp_chan
);

   cell_io_type cells [QUEUE_DEPTH];
   cell_io_type lefts [QUEUE_DEPTH];
   cell_io_type rights[QUEUE_DEPTH];
   ctl_type     ctl;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    accept, full, empty;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;
   assign full   = cells[QUEUE_DEPTH-1].valid;
   assign empty  = !cells[0].valid;

   assign ctl.ins       = accept && (req_chan.command == CMD_ADD) && !full;
   assign ctl.rem       = accept && (req_chan.command == CMD_REMOVE) && !empty;
   assign ctl.key.text  = req_chan.job_text;
   assign ctl.key.prio  = req_chan.job_priority;
   assign ctl.key.tag   = req_chan.arrival_tag;

   genvar i;
   generate
      for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         if (i == 0) begin : g_head
            assign lefts[i] = '{valid: 1'b1, take: 1'b0, entry: '0};
         end else begin : g_mid
            assign lefts[i] = cells[i-1];
         end
         if (i == QUEUE_DEPTH-1) begin : g_tail
            assign rights[i] = '{valid: 1'b0, take: 1'b0, entry: '0};
         end else begin : g_body
            assign rights[i] = cells[i+1];
         end
         spjq_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctl   (ctl),
            .left  (lefts[i]),
            .right (rights[i]),
            .own   (cells[i])
         );
      end
   endgenerate

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{status: ST_ADDED, text: '0, prio: '0, tag: '0};
         if (req_chan.command == CMD_ADD) begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end
         end else if (empty) begin
            rsp_in.status = ST_EMPTY;
         end else begin
            rsp_in.status = ST_REMOVED;
            rsp_in.text   = cells[0].entry.text;
            rsp_in.prio   = cells[0].entry.prio;
            rsp_in.tag    = cells[0].entry.tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_ff.status;
   assign rsp_chan.out_text     = rsp_ff.text;
   assign rsp_chan.out_priority = rsp_ff.prio;
   assign rsp_chan.out_tag      = rsp_ff.tag;

   generate
      for (i = 0; i + 1 < QUEUE_DEPTH; i++) begin : g_chk
         // live cells form a prefix
         a_prefix: assert property (@(posedge clock) disable iff (reset)
            cells[i+1].valid |-> cells[i].valid)
            else $error("hole in live cells");
         // live cells stay sorted
         a_sorted: assert property (@(posedge clock) disable iff (reset)
            cells[i+1].valid |-> !goes_before(cells[i+1].entry, cells[i].entry))
            else $error("cells out of order");
      end
   endgenerate

   a_remove: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.command == CMD_REMOVE && !empty)
      |=> (rsp_ff.status == ST_REMOVED) && rsp_valid_ff)
      else $error("remove not reported");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.command == CMD_ADD && full)
      |=> cells[QUEUE_DEPTH-1].valid && $stable(cells[0].entry))
      else $error("rejected add changed queue");

endmodule

// ----- rtl/spjq_cell.sv -----
module spjq_cell import spjq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  ctl_type     ctl,
   input  cell_io_type left,
   input  cell_io_type right,
   output cell_io_type own
);

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      take;

   // empty slot or new key ranks ahead of this one
   assign take = !valid_ff || goes_before(ctl.key, entry_ff);

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (ctl.ins) begin
         if (take) begin
            entry_in = left.take ? left.entry : ctl.key;
         end
         valid_in = valid_ff || left.valid;
      end else if (ctl.rem) begin
         entry_in = right.entry;
         valid_in = right.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign own.valid = valid_ff;
   assign own.take  = take;
   assign own.entry = entry_ff;

endmodule

// ----- dv/spjq_reply_checker.sv -----
module spjq_reply_checker import spjq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   spjq_req_if        req_chan,
   spjq_rsp_if        rsp_chan,
   output int         mismatches,
   output int         pending
);

   entry_type held_jobs[$];
   rsp_type   reply_due[$];
   entry_type seen_job;
   rsp_type   want_reply;
   rsp_type   got_reply;
   int        fail_total = 0;

   // sorted job list, head served first; equal keys keep arrival order
   function automatic rsp_type next_queue_reply(input logic cmd, input entry_type job);
      rsp_type r;
      int      pos;
      r = '0;
      if (cmd == CMD_ADD) begin
         if (held_jobs.size() >= QUEUE_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            pos = held_jobs.size();
            while (pos > 0 &&
                   {job.prio, job.tag} < {held_jobs[pos-1].prio, held_jobs[pos-1].tag}) begin
               pos--;
            end
            held_jobs.insert(pos, job);
            r.status = ST_ADDED;
         end
      end else if (held_jobs.size() == 0) begin
         r.status = ST_EMPTY;
      end else begin
         r.status = ST_REMOVED;
         r.text   = held_jobs[0].text;
         r.prio   = held_jobs[0].prio;
         r.tag    = held_jobs[0].tag;
         void'(held_jobs.pop_front());
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         held_jobs.delete();
         reply_due.delete();
         pending <= 0;
         mismatches <= fail_total;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            seen_job.text = req_chan.job_text;
            seen_job.prio = req_chan.job_priority;
            seen_job.tag  = req_chan.arrival_tag;
            reply_due.push_back(next_queue_reply(req_chan.command, seen_job));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got_reply.status = status_type'(rsp_chan.status);
            got_reply.text   = rsp_chan.out_text;
            got_reply.prio   = rsp_chan.out_priority;
            got_reply.tag    = rsp_chan.out_tag;
            if (reply_due.size() == 0) begin
               fail_total++;
               if (fail_total <= 10) begin
                  $display("unexpected reply word: status %0d text %h prio %h tag %h",
                           got_reply.status, got_reply.text, got_reply.prio, got_reply.tag);
               end
            end else begin
               want_reply = reply_due.pop_front();
               if (got_reply.status !== want_reply.status ||
                   got_reply.text   !== want_reply.text   ||
                   got_reply.prio   !== want_reply.prio   ||
                   got_reply.tag    !== want_reply.tag) begin
                  fail_total++;
                  if (fail_total <= 10) begin
                     $display("reply mismatch: expected status %0d text %h prio %h tag %h",
                              want_reply.status, want_reply.text, want_reply.prio,
                              want_reply.tag);
                     $display("                got      status %0d text %h prio %h tag %h",
                              got_reply.status, got_reply.text, got_reply.prio,
                              got_reply.tag);
                  end
               end
            end
         end
         pending <= reply_due.size();
         mismatches <= fail_total;
      end
   end

endmodule

// ----- dv/stable_priority_job_queue_core_tb.sv -----
module stable_priority_job_queue_core_tb;
   import spjq_pkg::*;

   localparam int RANDOM_WORDS = 950;
   localparam int CYCLE_LIMIT  = 200000;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic      clock;
   logic      reset;
   int        mismatches;
   int        pending;
   int        cycle_count = 0;

   rx_mode_type rx_mode;
   int        rx_left;

   entry_type job;
   int        sent;
   int        burst_len;
   int        gap;
   int        add_pct;
   int        k;

   spjq_req_if req_chan();
   spjq_rsp_if rsp_chan();

   stable_priority_job_queue_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   spjq_reply_checker u_chk (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver back-pressure
   initial begin
      rsp_chan.ready = 1'b0;
      rx_mode = RX_OPEN;
      rx_left = 0;
      forever begin
         @(posedge clock);
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_left = $urandom_range(10, 150);
         end
         rx_left--;
         case (rx_mode)
            RX_OPEN:   rsp_chan.ready <= 1'b1;
            RX_COIN:   rsp_chan.ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_chan.ready <= ((rx_left % 8) < 5);
         endcase
      end
   end

   function automatic entry_type make_job(input logic [31:0] text, input logic [15:0] prio,
                                          input logic [15:0] tag);
      entry_type e;
      e.text = text;
      e.prio = prio;
      e.tag  = tag;
      return e;
   endfunction

   // narrow key ranges most of the time so ties are common
   function automatic logic [15:0] random_key();
      logic [15:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: v = 16'($urandom_range(0, 3));
         6, 7, 8:          v = 16'($urandom);
         default:          v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      endcase
      return v;
   endfunction

   task automatic send_word(input logic cmd, input entry_type e);
      req_chan.valid        <= 1'b1;
      req_chan.command      <= cmd;
      req_chan.job_text     <= e.text;
      req_chan.job_priority <= e.prio;
      req_chan.arrival_tag  <= e.tag;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   task automatic drain_replies();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.command      = CMD_ADD;
      req_chan.job_text     = '0;
      req_chan.job_priority = '0;
      req_chan.arrival_tag  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty, extremes, ties, full, drain
      send_word(CMD_REMOVE, make_job(32'hFFFFFFFF, 16'hFFFF, 16'hFFFF));
      send_word(CMD_ADD,    make_job(32'h00000000, 16'hFFFF, 16'hFFFF));
      send_word(CMD_ADD,    make_job(32'hFFFFFFFF, 16'h0000, 16'h0000));
      send_word(CMD_ADD,    make_job("AAAA", 16'd5, 16'd7));
      send_word(CMD_ADD,    make_job("BBBB", 16'd5, 16'd7));
      send_word(CMD_ADD,    make_job("CCCC", 16'd5, 16'd3));
      send_word(CMD_ADD,    make_job("DDDD", 16'd5, 16'hFFFF));
      send_word(CMD_ADD,    make_job(32'h80000000, 16'h8000, 16'h8000));
      send_word(CMD_ADD,    make_job(32'h5A5AA5A5, 16'h0001, 16'hFFFF));
      send_word(CMD_ADD,    make_job(32'h12345678, 16'h0000, 16'h0000));
      repeat (8) send_word(CMD_REMOVE, make_job(32'h0, 16'h0, 16'h0));
      send_word(CMD_REMOVE, make_job(32'h0, 16'h0, 16'h0));
      send_word(CMD_ADD,    make_job(32'hA5A55A5A, 16'h7FFF, 16'h7FFF));
      send_word(CMD_ADD,    make_job(32'h0F0F0F0F, 16'h7FFF, 16'h7FFF));
      send_word(CMD_REMOVE, make_job(32'h0, 16'h0, 16'h0));
      send_word(CMD_REMOVE, make_job(32'h0, 16'h0, 16'h0));
      drain_replies();

      sent = 0;
      add_pct = 50;
      while (sent < RANDOM_WORDS) begin
         burst_len = $urandom_range(1, 24);
         case ($urandom_range(0, 3))
            0:       add_pct = 15;
            3:       add_pct = 85;
            default: add_pct = 50;
         endcase
         for (k = 0; k < burst_len && sent < RANDOM_WORDS; k++) begin
            job = make_job($urandom, random_key(), random_key());
            send_word(($urandom_range(1, 100) <= add_pct) ? CMD_ADD : CMD_REMOVE, job);
            sent++;
            if (sent == RANDOM_WORDS / 2) drain_replies();
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      drain_replies();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
